@@ hdl/slab_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared constants, codes and inter-module types for the page chunk allocator.
// ----------------------------------------------------------------------------
package slab_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 64;
  localparam int MAP_WORDS    = 8;
  localparam int WORD_BITS    = 32;
  localparam int MAP_BITS     = MAP_WORDS * WORD_BITS;

  // Usable bytes after the header; zero when the header fills the page
  localparam int ROOM_BYTES = (HEADER_BYTES < PAGE_BYTES) ? (PAGE_BYTES - HEADER_BYTES) : 0;

  localparam int OFF_W   = 12;
  localparam int CS_W    = 12;
  localparam int CAP_W   = $clog2(MAP_BITS + 1);
  localparam int IDX_W   = $clog2(MAP_BITS);
  localparam int WADDR_W = $clog2(MAP_WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int DIV_CNT_W = $clog2(OFF_W);

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  localparam logic [CS_W-1:0]  CS_RESET = CS_W'(64);
  localparam logic [OFF_W-1:0] HDR_V    = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] ROOM_V   = OFF_W'(ROOM_BYTES);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_BAD_OFFSET = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP_CAP,
    S_CAP_WAIT,
    S_PREP_OP,
    S_IDX_WAIT,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
    logic [CS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [OFF_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             en;
    logic             set;
    logic [IDX_W-1:0] idx;
  } map_wr_t;

endpackage

@@ hdl/slab_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle; shared by the capacity and
// the chunk index computations.
// ----------------------------------------------------------------------------
module slab_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slab_pkg::div_req_t req_i,
  output slab_pkg::div_rsp_t rsp_o
);
  import slab_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0]     rem_q, rem_d;
  logic [OFF_W-1:0]     quo_q, quo_d;
  logic [CS_W-1:0]      dvs_q, dvs_d;
  logic [OFF_W:0]       rem_sh;
  logic [OFF_W:0]       diff;

  always_comb begin
    rem_sh = {rem_q, quo_q[OFF_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift the next dividend bit in, subtract when it fits
      if (!diff[OFF_W]) begin
        rem_d = diff[OFF_W-1:0];
        quo_d = {quo_q[OFF_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[OFF_W-1:0];
        quo_d = {quo_q[OFF_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(OFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hdl/slab_map.sv @@
// ----------------------------------------------------------------------------
// Free map store
// One bit per chunk, 1 = free; one word read and one bit written per cycle.
// ----------------------------------------------------------------------------
module slab_map (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [slab_pkg::WADDR_W-1:0]      raddr_i,
  output logic [slab_pkg::WORD_BITS-1:0]    rdata_o,
  input  slab_pkg::map_wr_t                 wr_i
);
  import slab_pkg::*;

  logic [WORD_BITS-1:0] words_q [MAP_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        words_q[w] <= '1;
      end
    end else if (wr_i.en) begin
      words_q[wr_i.idx[IDX_W-1:BIT_W]][wr_i.idx[BIT_W-1:0]] <= wr_i.set;
    end
  end

  assign rdata_o = words_q[raddr_i];

endmodule

@@ hdl/slab_page_bitmap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Slab page bitmap allocator
// Hands out and takes back fixed-size chunks of one page from a free bitmap.
// ----------------------------------------------------------------------------
//  port group    dir  payload
//  s_axis_*      in   tuser[0] op, tdata[11:0] free_offset
//  m_axis_*      out  tuser[1:0] status, tdata[11:0] chunk_offset,
//                     tdata[12] became_full, tdata[13] reopened
//  cfg_*         in   cfg_wdata_i[11:0] chunk_size
//
//  Allocate scans the free map one word a cycle.
//  Free adds a pass of the serial divider (one quotient bit a cycle).
//  The first transaction after reset or a chunk_size write first derives
//  the capacity on the same divider.
//  s_axis_tready is low while a transaction is at work; a result waiting in
//  the output register does not block the next input transaction.
//  Reset is asynchronous and restores an all-free map and chunk_size 64.
// ----------------------------------------------------------------------------
module slab_page_bitmap_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [slab_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] free_offset
  input  logic                            s_axis_tuser,  // [0] op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [slab_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [11:0] chunk_offset,
                                                         // [12] became_full, [13] reopened
  output logic [slab_pkg::M_TUSER_W-1:0]  m_axis_tuser,  // [1:0] status
  input  logic                            cfg_we_i,
  input  logic [slab_pkg::CS_W-1:0]       cfg_wdata_i
);
  import slab_pkg::*;

  state_e             state_q, state_d;
  logic [CS_W-1:0]    cs_q, cs_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic               cap_valid_q, cap_valid_d;
  op_e                op_q, op_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [IDX_W-1:0]   chunk_q, chunk_d;
  logic [WADDR_W-1:0] scan_w_q, scan_w_d;
  logic               found_q, found_d;
  logic               another_q, another_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  status_e            res_status_q, res_status_d;
  logic [OFF_W-1:0]   res_offset_q, res_offset_d;
  logic               res_full_q, res_full_d;
  logic               res_reopen_q, res_reopen_d;

  logic               m_valid_q, m_valid_d;
  status_e            m_status_q, m_status_d;
  logic [OFF_W-1:0]   m_offset_q, m_offset_d;
  logic               m_full_q, m_full_d;
  logic               m_reopen_q, m_reopen_d;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  map_wr_t              map_wr;
  logic [WORD_BITS-1:0] map_word;

  logic                 s_accept;
  logic [CAP_W-1:0]     word_lo;
  logic [CAP_W-1:0]     cap_rel;
  logic [WORD_BITS-1:0] cap_mask;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] rest;
  logic [BIT_W-1:0]     low_pos;
  logic [IDX_W+CS_W-1:0] prod;

  slab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  slab_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (scan_w_q),
    .rdata_o (map_word),
    .wr_i    (map_wr)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Mask off map bits at or above the capacity for the word under scan
  always_comb begin
    word_lo = CAP_W'({scan_w_q, {BIT_W{1'b0}}});
    cap_rel = cap_q - word_lo;
    if (cap_q >= word_lo + CAP_W'(WORD_BITS)) begin
      cap_mask = '1;
    end else if (cap_q <= word_lo) begin
      cap_mask = '0;
    end else begin
      cap_mask = ~({WORD_BITS{1'b1}} << cap_rel[BIT_W-1:0]);
    end
    masked  = map_word & cap_mask;
    rest    = masked & (masked - 1'b1);
    low_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        low_pos = BIT_W'(i);
      end
    end
  end

  assign prod = idx_q * cs_q;

  always_comb begin
    state_d      = state_q;
    cs_d         = cs_q;
    cap_d        = cap_q;
    cap_valid_d  = cap_valid_q;
    op_d         = op_q;
    off_d        = off_q;
    chunk_d      = chunk_q;
    scan_w_d     = scan_w_q;
    found_d      = found_q;
    another_d    = another_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_offset_d = res_offset_q;
    res_full_d   = res_full_q;
    res_reopen_d = res_reopen_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_status_d   = m_status_q;
    m_offset_d   = m_offset_q;
    m_full_d     = m_full_q;
    m_reopen_d   = m_reopen_q;
    div_req      = '0;
    map_wr       = '0;

    if (cfg_we_i) begin
      cs_d        = cfg_wdata_i;
      cap_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          op_d         = op_e'(s_axis_tuser);
          off_d        = s_axis_tdata[OFF_W-1:0];
          res_status_d = STAT_OK;
          res_offset_d = '0;
          res_full_d   = 1'b0;
          res_reopen_d = 1'b0;
          state_d      = (cap_valid_q && !cfg_we_i) ? S_PREP_OP : S_PREP_CAP;
        end
      end
      S_PREP_CAP: begin
        if (cs_q == '0 || ROOM_V == '0) begin
          cap_d       = '0;
          cap_valid_d = 1'b1;
          state_d     = S_PREP_OP;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = ROOM_V;
          div_req.divisor  = cs_q;
          state_d          = S_CAP_WAIT;
        end
      end
      S_CAP_WAIT: begin
        if (div_rsp.done) begin
          cap_d       = (div_rsp.quotient >= OFF_W'(MAP_BITS)) ?
                        CAP_W'(MAP_BITS) : CAP_W'(div_rsp.quotient);
          cap_valid_d = 1'b1;
          state_d     = S_PREP_OP;
        end
      end
      S_PREP_OP: begin
        scan_w_d  = '0;
        found_d   = 1'b0;
        another_d = 1'b0;
        if (op_q == OP_ALLOC) begin
          state_d = S_SCAN;
        end else if (cap_q == '0 || off_q < HDR_V) begin
          res_status_d = STAT_BAD_OFFSET;
          state_d      = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = off_q - HDR_V;
          div_req.divisor  = cs_q;
          state_d          = S_IDX_WAIT;
        end
      end
      S_IDX_WAIT: begin
        if (div_rsp.done) begin
          chunk_d = div_rsp.quotient[IDX_W-1:0];
          if (div_rsp.quotient >= OFF_W'(cap_q)) begin
            res_status_d = STAT_BAD_OFFSET;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // first free chunk, and whether a second one exists past it
        if (!found_q) begin
          if (masked != '0) begin
            found_d   = 1'b1;
            idx_d     = {scan_w_q, low_pos};
            another_d = (rest != '0);
          end
        end else if (masked != '0) begin
          another_d = 1'b1;
        end
        scan_w_d = scan_w_q + 1'b1;
        if (scan_w_q == WADDR_W'(MAP_WORDS - 1)) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (op_q == OP_ALLOC) begin
          if (!found_q) begin
            res_status_d = STAT_NO_FREE;
          end else begin
            map_wr.en    = 1'b1;
            map_wr.set   = 1'b0;
            map_wr.idx   = idx_q;
            res_offset_d = HDR_V + prod[OFF_W-1:0];
            res_full_d   = !another_q;
          end
        end else begin
          map_wr.en    = 1'b1;
          map_wr.set   = 1'b1;
          map_wr.idx   = chunk_q;
          res_reopen_d = !found_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_offset_d = res_offset_q;
          m_full_d   = res_full_q;
          m_reopen_d = res_reopen_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cs_q        <= CS_RESET;
      cap_valid_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cs_q        <= cs_d;
      cap_valid_q <= cap_valid_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q        <= cap_d;
    op_q         <= op_d;
    off_q        <= off_d;
    chunk_q      <= chunk_d;
    scan_w_q     <= scan_w_d;
    found_q      <= found_d;
    another_q    <= another_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_offset_q <= res_offset_d;
    res_full_q   <= res_full_d;
    res_reopen_q <= res_reopen_d;
    m_status_q   <= m_status_d;
    m_offset_q   <= m_offset_d;
    m_full_q     <= m_full_d;
    m_reopen_q   <= m_reopen_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W - OFF_W - 2){1'b0}}, m_reopen_q, m_full_q, m_offset_q};

endmodule

@@ hdl/slab_checker.sv @@
// ----------------------------------------------------------------------------
// Slab allocator port checker
// Concurrent checks on the allocator ports, bound to the top level.
// ----------------------------------------------------------------------------
module slab_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [slab_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] free_offset
  input logic                            s_axis_tuser,  // [0] op
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [slab_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [11:0] chunk_offset,
                                                        // [12] became_full, [13] reopened
  input logic [slab_pkg::M_TUSER_W-1:0]  m_axis_tuser,  // [1:0] status
  input logic                            cfg_we_i,
  input logic [slab_pkg::CS_W-1:0]       cfg_wdata_i
);
  import slab_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one transaction at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_NO_FREE ||
                       m_axis_tuser == STAT_BAD_OFFSET))
    else $error("illegal status code");

  // a failed request carries no offset and no flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
    else $error("failed request with payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[OFF_W] && m_axis_tdata[OFF_W+1]))
    else $error("became_full and reopened together");

endmodule

bind slab_page_bitmap_allocator_core slab_checker u_slab_checker (.*);
